// File: sv/assert_macros.svh
// assertion macros shared by the tokenizer rtl
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/cst_pkg.sv
// shared types, token kind codes and keyword table for the tokenizer
// no dependencies
`timescale 1ns / 1ps

package cst_pkg;

  localparam int POS_BITS    = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] KIND_LPAREN = 4'd0;
  localparam logic [3:0] KIND_RPAREN = 4'd1;
  localparam logic [3:0] KIND_LBRACE = 4'd2;
  localparam logic [3:0] KIND_RBRACE = 4'd3;
  localparam logic [3:0] KIND_SEMI   = 4'd4;
  localparam logic [3:0] KIND_INT    = 4'd5;
  localparam logic [3:0] KIND_RETURN = 4'd6;
  localparam logic [3:0] KIND_IDENT  = 4'd7;
  localparam logic [3:0] KIND_NUMBER = 4'd8;
  localparam logic [3:0] KIND_END    = 4'd9;
  localparam logic [3:0] KIND_BAD    = 4'd10;

  localparam logic [1:0] CAND_NONE = 2'd0;
  localparam logic [1:0] CAND_INT  = 2'd1;
  localparam logic [1:0] CAND_RET  = 2'd2;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  bad;
    logic        last;
  } token_t;

  // expected letter at position idx of the keyword under test
  function automatic logic [7:0] kw_char(input logic [1:0] cand, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (cand)
      CAND_INT: begin
        case (idx)
          3'd0: ch = "i";
          3'd1: ch = "n";
          3'd2: ch = "t";
          default: ch = 8'h00;
        endcase
      end
      CAND_RET: begin
        case (idx)
          3'd0: ch = "r";
          3'd1: ch = "e";
          3'd2: ch = "t";
          3'd3: ch = "u";
          3'd4: ch = "r";
          3'd5: ch = "n";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: sv/cst_scan.sv
// scanner state and per-byte token decode, up to two tokens per byte
// depends on cst_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cst_scan (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     text_byte,
  output logic [1:0]     res_n,
  output cst_pkg::token_t res0,
  output cst_pkg::token_t res1
);
  import cst_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WORD = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;
  localparam logic [1:0] MODE_DROP = 2'd3;

  logic [1:0]          mode, mode_next;
  logic [POS_BITS-1:0] pos, pos_next;
  logic [POS_BITS-1:0] begin_pos, begin_pos_next;
  logic [15:0]         count, count_next;
  logic [1:0]          cand, cand_next;
  logic [2:0]          matched, matched_next;

  logic        is_letter, is_digit, is_space;
  logic        close_use, own_valid, kw_hit;
  logic [3:0]  word_kind;
  logic [15:0] count_inc;
  logic [1:0]  cand_start;
  token_t      close_tok, own_tok;
  logic [1:0]  n;

  assign is_letter = ((text_byte >= "a") && (text_byte <= "z")) ||
                     ((text_byte >= "A") && (text_byte <= "Z"));
  assign is_digit  = (text_byte >= "0") && (text_byte <= "9");
  assign is_space  = (text_byte == " ") || (text_byte == 8'h0D) ||
                     (text_byte == 8'h09) || (text_byte == 8'h0A);

  assign count_inc = (count == LEN_MAX) ? count : count + 16'd1;

  assign kw_hit = ((cand == CAND_INT) && (matched < 3'd3) &&
                   (text_byte == kw_char(CAND_INT, matched))) ||
                  ((cand == CAND_RET) && (matched < 3'd6) &&
                   (text_byte == kw_char(CAND_RET, matched)));

  assign cand_start = (text_byte == "i") ? CAND_INT :
                      (text_byte == "r") ? CAND_RET : CAND_NONE;

  always_comb begin
    word_kind = KIND_IDENT;
    if ((cand == CAND_INT) && (matched == 3'd3)) word_kind = KIND_INT;
    if ((cand == CAND_RET) && (matched == 3'd6)) word_kind = KIND_RETURN;
  end

  always_comb begin
    close_tok.kind   = (mode == MODE_WORD) ? word_kind : KIND_NUMBER;
    close_tok.start  = 16'(begin_pos);
    close_tok.length = count;
    close_tok.bad    = 8'h00;
    close_tok.last   = 1'b0;
  end

  always_comb begin
    mode_next      = mode;
    pos_next       = pos;
    begin_pos_next = begin_pos;
    count_next     = count;
    cand_next      = cand;
    matched_next   = matched;
    close_use      = 1'b0;
    own_valid      = 1'b0;
    own_tok.kind   = KIND_END;
    own_tok.start  = 16'(pos);
    own_tok.length = 16'd1;
    own_tok.bad    = 8'h00;
    own_tok.last   = 1'b0;

    if (text_byte == 8'h00) begin
      // end of text: flush open run, emit end, back to reset state
      close_use      = (mode == MODE_WORD) || (mode == MODE_NUM);
      own_valid      = 1'b1;
      own_tok.length = 16'd0;
      mode_next      = MODE_IDLE;
      pos_next       = '0;
      begin_pos_next = '0;
      count_next     = '0;
      cand_next      = CAND_NONE;
      matched_next   = 3'd0;
    end else if (mode == MODE_DROP) begin
      pos_next = pos + 1'b1;
    end else if ((mode == MODE_WORD) && is_letter) begin
      count_next = count_inc;
      if (kw_hit) begin
        matched_next = matched + 3'd1;
      end else begin
        cand_next    = CAND_NONE;
        matched_next = 3'd0;
      end
      pos_next = pos + 1'b1;
    end else if ((mode == MODE_NUM) && is_digit) begin
      count_next = count_inc;
      pos_next   = pos + 1'b1;
    end else begin
      close_use = (mode == MODE_WORD) || (mode == MODE_NUM);
      if (close_use) begin
        mode_next    = MODE_IDLE;
        cand_next    = CAND_NONE;
        matched_next = 3'd0;
      end
      if (is_letter) begin
        mode_next      = MODE_WORD;
        begin_pos_next = pos;
        count_next     = 16'd1;
        cand_next      = cand_start;
        matched_next   = (cand_start != CAND_NONE) ? 3'd1 : 3'd0;
      end else if (is_digit) begin
        mode_next      = MODE_NUM;
        begin_pos_next = pos;
        count_next     = 16'd1;
        cand_next      = CAND_NONE;
        matched_next   = 3'd0;
      end else if (!is_space) begin
        own_valid = 1'b1;
        case (text_byte)
          "(":     own_tok.kind = KIND_LPAREN;
          ")":     own_tok.kind = KIND_RPAREN;
          "{":     own_tok.kind = KIND_LBRACE;
          "}":     own_tok.kind = KIND_RBRACE;
          ";":     own_tok.kind = KIND_SEMI;
          default: begin
            own_tok.kind = KIND_BAD;
            own_tok.bad  = text_byte;
            mode_next    = MODE_DROP;
          end
        endcase
      end
      pos_next = pos + 1'b1;
    end
  end

  // pack results in order, flag the final one
  always_comb begin
    res0 = '0;
    res1 = '0;
    n    = 2'd0;
    if (close_use) begin
      res0 = close_tok;
      if (own_valid) begin
        res1      = own_tok;
        res1.last = 1'b1;
        n         = 2'd2;
      end else begin
        res0.last = 1'b1;
        n         = 2'd1;
      end
    end else if (own_valid) begin
      res0      = own_tok;
      res0.last = 1'b1;
      n         = 2'd1;
    end
  end

  assign res_n = accept ? n : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      pos       <= '0;
      begin_pos <= '0;
      count     <= '0;
      cand      <= CAND_NONE;
      matched   <= 3'd0;
    end else if (accept) begin
      mode      <= mode_next;
      pos       <= pos_next;
      begin_pos <= begin_pos_next;
      count     <= count_next;
      cand      <= cand_next;
      matched   <= matched_next;
    end
  end

  // two tokens only when a word or number is flushed first
  `ASSERT_IMPLIES(a_pair_starts_with_run, clk, rst, res_n == 2'd2,
    (res0.kind == KIND_IDENT) || (res0.kind == KIND_NUMBER) ||
    (res0.kind == KIND_INT) || (res0.kind == KIND_RETURN))
  // dropping bytes after an error stays silent until end of text
  `ASSERT_IMPLIES(a_drop_silent, clk, rst,
    accept && (mode == MODE_DROP) && (text_byte != 8'h00), res_n == 2'd0)
  // a keyword match never runs past its keyword length
  `ASSERT_ALWAYS(a_match_bound, clk, rst,
    ((cand == CAND_INT) && (matched <= 3'd3)) ||
    ((cand == CAND_RET) && (matched <= 3'd6)) ||
    ((cand == CAND_NONE) && (matched == 3'd0)))

endmodule

// File: sv/cst_queue.sv
// small result queue, takes up to two tokens per cycle, hands out one
// depends on cst_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cst_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_n,
  input  cst_pkg::token_t push0,
  input  cst_pkg::token_t push1,
  input  logic            pop,
  output cst_pkg::token_t head,
  output logic            not_empty,
  output logic            room
);
  import cst_pkg::*;

  token_t               mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr, rptr;
  logic [QCNT_BITS-1:0] count, count_next;
  logic [QPTR_BITS-1:0] wptr_inc;

  assign wptr_inc  = wptr + 1'b1;
  assign head      = mem[rptr];
  assign not_empty = (count != '0);
  // room for a full pair of tokens
  assign room      = (count <= QCNT_BITS'(QUEUE_DEPTH - 2));

  assign count_next = count + QCNT_BITS'(push_n) - QCNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wptr] <= push0;
    if (push_n == 2'd2) mem[wptr_inc] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QPTR_BITS'(push_n);
      if (pop) rptr <= rptr + 1'b1;
      count <= count_next;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= QCNT_BITS'(QUEUE_DEPTH))
  `ASSERT_IMPLIES(a_push_has_room, clk, rst, push_n != 2'd0,
    count <= QCNT_BITS'(QUEUE_DEPTH - 2))
  `ASSERT_IMPLIES(a_pop_not_empty, clk, rst, pop, count != '0)

endmodule

// File: sv/c_subset_tokenizer.sv
// channel | dir | handshake                 | beat payload
// text    | in  | text_valid / text_ready   | text_byte
// token   | out | token_valid / token_ready | token_kind, token_start, token_length,
//         |     |                           | bad_byte, last_of_run
//
// one text beat per clock while text_ready is high; the byte is decoded
// in the same cycle it is taken and its tokens land in a four-entry result queue
// a byte that closes a word or number and starts a mark gives two token beats,
// so the token side drains one beat per clock when ready and may hold off text
// text_ready is high while the queue has room for two tokens
// synchronous reset clears the scanner to idle, position zero, queue empty
// depends on cst_pkg, cst_scan, cst_queue
`timescale 1ns / 1ps

module c_subset_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_ready,
  input  logic [7:0]  text_byte,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [3:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic [7:0]  bad_byte,
  output logic        last_of_run
);
  import cst_pkg::*;

  logic   accept;
  logic   pop;
  logic   room;
  logic   not_empty;
  logic [1:0] res_n;
  token_t res0, res1, head;

  // a text beat goes in whenever a whole pair of tokens still fits
  assign text_ready = room;
  assign accept     = text_valid && room;

  // decode: state registers plus per-byte token logic
  cst_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (text_byte),
    .res_n     (res_n),
    .res0      (res0),
    .res1      (res1)
  );

  // result queue decouples the two sides; token stalls block decoding only once it lacks room for a pair
  assign pop = token_valid && token_ready;

  cst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (res_n),
    .push0     (res0),
    .push1     (res1),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room      (room)
  );

  // token beat straight from the queue head
  assign token_valid  = not_empty;
  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign bad_byte     = head.bad;
  assign last_of_run  = head.last;

endmodule
